[hw/rtl/bres_pkg.sv]
// ----------------------------------------------------------------------------
// bres_pkg
// shared word types and codes of the line rasterizer
// ----------------------------------------------------------------------------
package bres_pkg;

  localparam int FIELD_W = 10;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [FIELD_W-1:0] start_x;
    logic [FIELD_W-1:0] start_y;
    logic [FIELD_W-1:0] end_x;
    logic [FIELD_W-1:0] end_y;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0] pixel_x;
    logic [FIELD_W-1:0] pixel_y;
    logic               last_pixel;
  } out_word_t;

endpackage

[hw/rtl/bres_setup.sv]
// ----------------------------------------------------------------------------
// bres_setup
// line setup from two endpoints: deltas, directions, steep flag, start terms
// ----------------------------------------------------------------------------
module bres_setup #(
  parameter int COORD_BITS = 10
) (
  input  bres_pkg::in_word_t       word_i,
  output logic                     steep_o,
  output logic [COORD_BITS-1:0]    major_o,
  output logic [COORD_BITS-1:0]    minor_o,
  output logic [COORD_BITS-1:0]    delta_major_o,
  output logic [COORD_BITS-1:0]    delta_minor_o,
  output logic                     dir_major_neg_o,
  output logic                     dir_minor_neg_o,
  output logic signed [COORD_BITS+2:0] decision_o,
  output logic [COORD_BITS:0]      pixels_left_o
);

  localparam int CW = COORD_BITS;
  localparam int PW = COORD_BITS + 1;

  logic [CW-1:0] sx, sy, ex, ey, dx, dy;
  logic          xneg, yneg;

  assign sx = CW'(word_i.start_x);
  assign sy = CW'(word_i.start_y);
  assign ex = CW'(word_i.end_x);
  assign ey = CW'(word_i.end_y);

  assign xneg = ex < sx;
  assign yneg = ey < sy;
  assign dx   = xneg ? sx - ex : ex - sx;
  assign dy   = yneg ? sy - ey : ey - sy;

  assign steep_o         = dy > dx;
  assign major_o         = steep_o ? sy : sx;
  assign minor_o         = steep_o ? sx : sy;
  assign delta_major_o   = steep_o ? dy : dx;
  assign delta_minor_o   = steep_o ? dx : dy;
  assign dir_major_neg_o = steep_o ? yneg : xneg;
  assign dir_minor_neg_o = steep_o ? xneg : yneg;

  // 2*dminor - dmajor
  assign decision_o = $signed({2'b00, delta_minor_o, 1'b0})
                    - $signed({3'b000, delta_major_o});
  assign pixels_left_o = {1'b0, delta_major_o} + PW'(1);

endmodule

[hw/rtl/bres_core.sv]
// ----------------------------------------------------------------------------
// bres_core
// line state, one bresenham step per cycle and the result register
// ----------------------------------------------------------------------------
module bres_core #(
  parameter int COORD_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  bres_pkg::in_word_t  item_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output bres_pkg::out_word_t out_word_o
);

  localparam int CW = COORD_BITS;
  localparam int DW = COORD_BITS + 3;
  localparam int PW = COORD_BITS + 1;
  localparam int FW = bres_pkg::FIELD_W;

  logic                 steep_q, steep_d;
  logic [CW-1:0]        major_q, major_d, minor_q, minor_d;
  logic [CW-1:0]        dmaj_q, dmaj_d, dmin_q, dmin_d;
  logic                 majneg_q, majneg_d, minneg_q, minneg_d;
  logic signed [DW-1:0] dec_q, dec_d;
  logic [PW-1:0]        left_q, left_d;
  logic                 active_q, active_d;
  logic                 out_valid_q, out_valid_d;
  bres_pkg::out_word_t  out_word_q, out_word_d;

  logic                 su_steep, su_majneg, su_minneg;
  logic [CW-1:0]        su_major, su_minor, su_dmaj, su_dmin;
  logic signed [DW-1:0] su_dec;
  logic [PW-1:0]        su_left;

  logic                 do_load, do_step, last, dec_pos;
  logic signed [DW-1:0] two_min, two_maj;

  bres_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .word_i          (item_i),
    .steep_o         (su_steep),
    .major_o         (su_major),
    .minor_o         (su_minor),
    .delta_major_o   (su_dmaj),
    .delta_minor_o   (su_dmin),
    .dir_major_neg_o (su_majneg),
    .dir_minor_neg_o (su_minneg),
    .decision_o      (su_dec),
    .pixels_left_o   (su_left)
  );

  assign do_load = item_valid_i && (item_i.kind == bres_pkg::KIND_LOAD);
  assign do_step = item_valid_i && (item_i.kind == bres_pkg::KIND_STEP) && active_q;
  assign last    = left_q <= PW'(1);
  assign dec_pos = !dec_q[DW-1] && (dec_q != '0);
  assign two_min = $signed({2'b00, dmin_q, 1'b0});
  assign two_maj = $signed({2'b00, dmaj_q, 1'b0});

  always_comb begin
    steep_d     = steep_q;
    major_d     = major_q;
    minor_d     = minor_q;
    dmaj_d      = dmaj_q;
    dmin_d      = dmin_q;
    majneg_d    = majneg_q;
    minneg_d    = minneg_q;
    dec_d       = dec_q;
    left_d      = left_q;
    active_d    = active_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (do_load) begin
      steep_d  = su_steep;
      major_d  = su_major;
      minor_d  = su_minor;
      dmaj_d   = su_dmaj;
      dmin_d   = su_dmin;
      majneg_d = su_majneg;
      minneg_d = su_minneg;
      dec_d    = su_dec;
      left_d   = su_left;
      active_d = 1'b1;
    end else if (do_step) begin
      out_valid_d           = 1'b1;
      out_word_d.pixel_x    = steep_q ? FW'(minor_q) : FW'(major_q);
      out_word_d.pixel_y    = steep_q ? FW'(major_q) : FW'(minor_q);
      out_word_d.last_pixel = last;
      if (dec_pos) begin
        minor_d = minneg_q ? minor_q - CW'(1) : minor_q + CW'(1);
        dec_d   = dec_q + two_min - two_maj;
      end else begin
        dec_d   = dec_q + two_min;
      end
      major_d = majneg_q ? major_q - CW'(1) : major_q + CW'(1);
      if (last) begin
        left_d   = '0;
        active_d = 1'b0;
      end else begin
        left_d   = left_q - PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steep_q     <= 1'b0;
      major_q     <= '0;
      minor_q     <= '0;
      dmaj_q      <= '0;
      dmin_q      <= '0;
      majneg_q    <= 1'b0;
      minneg_q    <= 1'b0;
      dec_q       <= '0;
      left_q      <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      steep_q     <= steep_d;
      major_q     <= major_d;
      minor_q     <= minor_d;
      dmaj_q      <= dmaj_d;
      dmin_q      <= dmin_d;
      majneg_q    <= majneg_d;
      minneg_q    <= minneg_d;
      dec_q       <= dec_d;
      left_q      <= left_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[hw/rtl/bresenham_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// integer line rasterizer, one pixel per clock unless the output stalls, all eight octants
// ----------------------------------------------------------------------------
// input channel (in_valid_i / in_stall_o / in_word_i): a load word carries
// two endpoints and replaces any line in progress; a step word asks for the
// next pixel. a step word with no line loaded gives nothing.
// output channel (out_valid_o / out_stall_i / out_word_o): one word per pixel,
// start point to end point inclusive, last_pixel set on the end point.
// a step word passes the input register and then the result register before
// its pixel shows. throughput: one word per cycle in either direction while
// the output does not stall; each step updates the line state combinationally.
// the input register and the result register separate the two channels.
// when the receiver stalls, the pixel holds in the result register, one more
// word waits in the input register, then in_stall_o rises.
// reset clears the line state: no line is active until a load word.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer #(
  parameter int COORD_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bres_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bres_pkg::out_word_t out_word_o
);

  logic               in_valid_q, in_valid_d;
  bres_pkg::in_word_t in_word_q;
  logic               advance, accept;

  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q && !advance;
    if (accept) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_word_q <= in_word_i;
    end
  end

  bres_core #(.COORD_BITS(COORD_BITS)) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_q && advance),
    .item_i       (in_word_q),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_word_o   (out_word_o)
  );

endmodule

[hw/rtl/bres_checker.sv]
// ----------------------------------------------------------------------------
// bres_checker
// port-level checks of the line rasterizer, bound to the top level
// ----------------------------------------------------------------------------
module bres_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input bres_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input bres_pkg::out_word_t out_word_o
);

  logic unused_in;
  assign unused_in = in_valid_i ^ (^in_word_i);

  // stalled pixel holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // input stalls only under output back-pressure
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // end point taken: line is done, nothing follows at once
  a_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_word_o.last_pixel |=> !out_valid_o)
    else $error("pixel right after the end point");

  // a fresh pixel comes only from an unstalled input stage
  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_stall_o))
    else $error("output rose while input stage was stalled");

endmodule

bind bresenham_line_rasterizer bres_checker u_bres_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
